### sv/sepq_pkg.sv
// Package for the sorted event priority queue: sizes, codes, payload and control types.
`timescale 1ns / 1ps
package sepq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned TIME_BITS   = 16;
  localparam int unsigned KIND_BITS   = 3;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W     = TIME_BITS + KIND_BITS;

  // Request command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] evt_time;
    logic [KIND_BITS-1:0] evt_kind;
  } entry_t;

  typedef struct packed {
    logic                 cmd;
    logic [TIME_BITS-1:0] event_time;
    logic [KIND_BITS-1:0] event_kind;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [TIME_BITS-1:0] popped_time;
    logic [KIND_BITS-1:0] popped_kind;
    logic                 now_empty;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_req;
    logic    rd_prev;
    logic    wr_shift;
    logic    wr_new;
    logic    pop_commit;
    logic    ins_commit;
    logic    res_load;
    logic    res_from_ram;
    status_e res_status;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic req_pop;
    logic j_zero;
    logic later;
  } dp_stat_t;

  // Physical slot of a logical offset from the head of the circular store
  function automatic idx_t wrap_add(input idx_t base, input idx_t off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

### sv/sepq_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sepq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/sepq_dp.sv
// Datapath: circular sorted store, head and occupancy, request and result registers.
`timescale 1ns / 1ps
module sepq_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sepq_pkg::req_t      req_i,
  input  sepq_pkg::ctrl_cmd_t cmd_i,
  output sepq_pkg::dp_stat_t  stat_o,
  output sepq_pkg::res_t      result_o
);

  sepq_pkg::idx_t                      head_q, head_d;
  sepq_pkg::cnt_t                      occ_q, occ_d;
  sepq_pkg::cnt_t                      j_q, j_d;
  logic [sepq_pkg::TIME_BITS-1:0]      t_q;
  logic [sepq_pkg::KIND_BITS-1:0]      k_q;
  sepq_pkg::res_t                      res_q;
  sepq_pkg::entry_t                    rd_entry;
  sepq_pkg::entry_t                    wr_entry;
  logic [sepq_pkg::ENTRY_W-1:0]        rdata;
  sepq_pkg::idx_t                      j_idx;
  sepq_pkg::idx_t                      waddr, raddr;
  logic                                we;

  assign rd_entry = sepq_pkg::entry_t'(rdata);
  assign j_idx    = j_q[sepq_pkg::IDX_W-1:0];

  // Store addressing: head for pop, logical j-1 for the insert scan, logical j for writes
  always_comb begin
    raddr = head_q;
    if (cmd_i.rd_prev) begin
      raddr = sepq_pkg::wrap_add(head_q, j_idx - sepq_pkg::idx_t'(1));
    end
    waddr = sepq_pkg::wrap_add(head_q, j_idx);
    we    = cmd_i.wr_shift | cmd_i.wr_new;
    if (cmd_i.wr_new) begin
      wr_entry.evt_time = t_q;
      wr_entry.evt_kind = k_q;
    end else begin
      wr_entry = rd_entry;
    end
  end

  sepq_ram #(
    .WIDTH(sepq_pkg::ENTRY_W),
    .DEPTH(sepq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_entry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Head, occupancy and scan index updates
  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    j_d    = j_q;
    if (cmd_i.load_req) begin
      j_d = occ_q;
    end
    if (cmd_i.wr_shift) begin
      j_d = j_q - sepq_pkg::cnt_t'(1);
    end
    if (cmd_i.pop_commit) begin
      occ_d = occ_q - sepq_pkg::cnt_t'(1);
      if (head_q == sepq_pkg::idx_t'(sepq_pkg::QUEUE_DEPTH - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + sepq_pkg::idx_t'(1);
      end
    end
    if (cmd_i.ins_commit) begin
      occ_d = occ_q + sepq_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      j_q    <= '0;
    end else begin
      head_q <= head_d;
      occ_q  <= occ_d;
      j_q    <= j_d;
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      t_q <= req_i.event_time;
      k_q <= req_i.event_kind;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.status <= cmd_i.res_status;
      if (cmd_i.res_from_ram) begin
        res_q.popped_time <= rd_entry.evt_time;
        res_q.popped_kind <= rd_entry.evt_kind;
      end else begin
        res_q.popped_time <= '0;
        res_q.popped_kind <= '0;
      end
      if (cmd_i.pop_commit) begin
        res_q.now_empty <= (occ_q == sepq_pkg::cnt_t'(1));
      end else if (cmd_i.ins_commit) begin
        res_q.now_empty <= 1'b0;
      end else begin
        res_q.now_empty <= (occ_q == '0);
      end
    end
  end

  assign result_o = res_q;

  // Status back to the controller
  assign stat_o.empty   = (occ_q == '0);
  assign stat_o.full    = (occ_q == sepq_pkg::cnt_t'(sepq_pkg::QUEUE_DEPTH));
  assign stat_o.req_pop = (req_i.cmd == sepq_pkg::CMD_POP);
  assign stat_o.j_zero  = (j_q == '0);
  assign stat_o.later   = (rd_entry.evt_time > t_q);

endmodule

### sv/sepq_ctrl.sv
// Controller: sequences pop, error replies and the insert shift scan.
`timescale 1ns / 1ps
module sepq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  sepq_pkg::dp_stat_t  stat_i,
  output logic                busy,
  output logic                done_o,
  output sepq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_INS_RD,
    ST_INS_CMP
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.res_status = sepq_pkg::STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          if (stat_i.req_pop) begin
            if (stat_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sepq_pkg::STATUS_EMPTY;
              done_d           = 1'b1;
            end else begin
              // store read port sits on the head while idle
              state_d = ST_POP_WAIT;
            end
          end else if (stat_i.full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = sepq_pkg::STATUS_FULL;
            done_d           = 1'b1;
          end else begin
            state_d = ST_INS_RD;
          end
        end
      end
      ST_POP_WAIT: begin
        cmd_o.res_load     = 1'b1;
        cmd_o.res_from_ram = 1'b1;
        cmd_o.pop_commit   = 1'b1;
        done_d             = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_INS_RD: begin
        if (stat_i.j_zero) begin
          cmd_o.wr_new     = 1'b1;
          cmd_o.ins_commit = 1'b1;
          cmd_o.res_load   = 1'b1;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // Later entries move up one slot; equal times stay ahead of the new event
        if (stat_i.later) begin
          cmd_o.wr_shift = 1'b1;
          state_d        = ST_INS_RD;
        end else begin
          cmd_o.wr_new     = 1'b1;
          cmd_o.ins_commit = 1'b1;
          cmd_o.res_load   = 1'b1;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

### sv/sorted_event_priority_queue.sv
// Top level: time-ordered event queue with FIFO order among equal times.
// Sequence: pop on empty and insert into full answer in the cycle after the request; a pop
// passes ST_POP_WAIT while the head is read. An insert passes ST_INS_RD and ST_INS_CMP once
// per shift, S being the stored events later than the new one, then writes the new event.
// Throughput: busy covers a pop or insert job up to its result; a new request may be taken in the strobe cycle.
// Reset clears occupancy and head; the event store is not cleared. No receiver stall.
`timescale 1ns / 1ps
module sorted_event_priority_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sepq_pkg::req_t   req_i,
  output logic             done_o,
  output sepq_pkg::res_t   result_o
);

  sepq_pkg::ctrl_cmd_t ctrl_cmd;
  sepq_pkg::dp_stat_t  dp_stat;

  sepq_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .stat_i(dp_stat),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (ctrl_cmd)
  );

  sepq_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (ctrl_cmd),
    .stat_o  (dp_stat),
    .result_o(result_o)
  );

  // A result strobe only comes once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // Every accepted request either answers at once or starts a multi-cycle job
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> (busy || done_o))
    else $error("accepted request dropped");

  // An empty-queue pop reports an empty queue and zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == sepq_pkg::STATUS_EMPTY) |->
      (result_o.now_empty && result_o.popped_time == '0 && result_o.popped_kind == '0))
    else $error("bad empty pop result");

  // A successful insert never leaves the queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(ctrl_cmd.ins_commit)) |-> !result_o.now_empty)
    else $error("insert reported empty queue");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sorted event priority queue: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import sepq_pkg::*;

  localparam int DIR_ROWS     = 23;
  localparam int TOTAL_ITEMS  = 850;
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

  // Random stimulus phases
  typedef enum logic [1:0] {
    PH_MIX,
    PH_FILL,
    PH_DRAIN
  } phase_e;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t want;
  } dir_row_t;

  localparam res_t NO_CHECK  = '{STATUS_OK, 16'd0, 3'd0, 1'b0};
  localparam res_t POP_EMPTY = '{STATUS_EMPTY, 16'd0, 3'd0, 1'b1};
  localparam res_t INS_OK    = '{STATUS_OK, 16'd0, 3'd0, 1'b0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t result_o;

  // Typed expectation travels with the request it belongs to
  logic exp_typed = 1'b0;
  res_t exp_fixed = NO_CHECK;

  // Predicted event store
  logic [TIME_BITS-1:0] sched_time [QUEUE_DEPTH];
  logic [KIND_BITS-1:0] sched_kind [QUEUE_DEPTH];
  int                   sched_count = 0;

  res_t outcome_q [$];
  int   errors      = 0;
  int   issued      = 0;
  int   drive_count = 0;

  // Directed table: typed results only where obvious
  dir_row_t script [DIR_ROWS] = '{
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b1, POP_EMPTY},
    '{'{CMD_INSERT, 16'h0000, 3'd0}, 1'b1, INS_OK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b1, '{STATUS_OK, 16'h0000, 3'd0, 1'b1}},
    '{'{CMD_INSERT, 16'hFFFF, 3'd7}, 1'b1, INS_OK},
    '{'{CMD_INSERT, 16'h8000, 3'd5}, 1'b0, NO_CHECK},
    '{'{CMD_INSERT, 16'h8000, 3'd2}, 1'b0, NO_CHECK},
    '{'{CMD_INSERT, 16'h0001, 3'd1}, 1'b0, NO_CHECK},
    '{'{CMD_INSERT, 16'h8000, 3'd6}, 1'b0, NO_CHECK},
    '{'{CMD_INSERT, 16'hAAAA, 3'd3}, 1'b0, NO_CHECK},
    '{'{CMD_INSERT, 16'h5555, 3'd4}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'hFFFF, 3'd7}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h1234, 3'd5}, 1'b1, POP_EMPTY},
    '{'{CMD_INSERT, 16'hFFFF, 3'd0}, 1'b1, INS_OK},
    '{'{CMD_INSERT, 16'h0000, 3'd7}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b0, NO_CHECK},
    '{'{CMD_POP,    16'h0000, 3'd0}, 1'b1, POP_EMPTY}
  };

  sorted_event_priority_queue DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one request to the predicted store and return its result
  function automatic res_t apply_to_schedule(input req_t r);
    res_t o;
    int   pos;
    int   i;
    o = NO_CHECK;
    if (r.cmd == CMD_POP) begin
      if (sched_count == 0) begin
        o.status = STATUS_EMPTY;
      end else begin
        o.popped_time = sched_time[0];
        o.popped_kind = sched_kind[0];
        for (i = 1; i < sched_count; i++) begin
          sched_time[i-1] = sched_time[i];
          sched_kind[i-1] = sched_kind[i];
        end
        sched_count--;
      end
    end else if (sched_count >= QUEUE_DEPTH) begin
      o.status = STATUS_FULL;
    end else begin
      // new event goes behind all equal times
      pos = 0;
      while (pos < sched_count && sched_time[pos] <= r.event_time) pos++;
      for (i = sched_count; i > pos; i--) begin
        sched_time[i] = sched_time[i-1];
        sched_kind[i] = sched_kind[i-1];
      end
      sched_time[pos] = r.event_time;
      sched_kind[pos] = r.event_kind;
      sched_count++;
    end
    o.now_empty = (sched_count == 0);
    return o;
  endfunction

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result check and request capture
  always @(posedge clk_i) begin : monitor
    res_t want;
    res_t pred;
    if (rst_ni) begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual %p", $time, result_o);
        end else begin
          want = outcome_q.pop_front();
          report_field("status", 16'(want.status), 16'(result_o.status));
          report_field("popped_time", want.popped_time, result_o.popped_time);
          report_field("popped_kind", 16'(want.popped_kind), 16'(result_o.popped_kind));
          report_field("now_empty", 16'(want.now_empty), 16'(result_o.now_empty));
        end
      end
      if (start && !busy) begin
        pred = apply_to_schedule(req_i);
        outcome_q.push_back(exp_typed ? exp_fixed : pred);
      end
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_request(input req_t r, input logic typed, input res_t want);
    int gap;
    int idle_pct;
    idle_pct = (issued < TOTAL_ITEMS / 3) ? 34 : (issued < 2 * TOTAL_ITEMS / 3) ? 67 : 0;
    // each cycle the sender idles with odds set by how many requests have been issued so far
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    req_i     <= r;
    exp_typed <= typed;
    exp_fixed <= want;
    do @(posedge clk_i); while (busy);
    issued++;
    if (r.cmd == CMD_INSERT && drive_count < QUEUE_DEPTH) drive_count++;
    if (r.cmd == CMD_POP && drive_count > 0) drive_count--;
  endtask

  // Random request; times lean toward extremes and ties
  function automatic req_t random_request(input int insert_pct);
    req_t r;
    r.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP;
    case ($urandom_range(0, 9))
      0:       r.event_time = 16'h0000;
      1:       r.event_time = 16'hFFFF;
      2, 3, 4: r.event_time = 16'($urandom_range(0, 7) * 4096);
      default: r.event_time = 16'($urandom_range(0, 65535));
    endcase
    r.event_kind = 3'($urandom_range(0, 7));
    return r;
  endfunction

  task automatic send_random(input int insert_pct);
    send_request(random_request(insert_pct), 1'b0, NO_CHECK);
  endtask

  initial begin : stimulus
    phase_e phase;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[n]) send_request(script[n].req, script[n].typed, script[n].want);

    // Random phases: fill past full, drain past empty, mixed traffic
    while (issued < TOTAL_ITEMS) begin
      phase = phase_e'($urandom_range(0, 2));
      case (phase)
        PH_FILL: begin
          while (drive_count < QUEUE_DEPTH) send_random(90);
          repeat ($urandom_range(1, 4)) send_random(100);
        end
        PH_DRAIN: begin
          while (drive_count > 0) send_random(10);
          repeat ($urandom_range(1, 3)) send_random(0);
        end
        default: begin
          repeat ($urandom_range(10, 60)) send_random(50);
        end
      endcase
    end
    start <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
